FILE: design/mse_pkg.sv
// Shared types and constants for the merge sort engine.
// No dependencies; every other design file imports this package.
package mse_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;
    localparam int Q_DEPTH      = 2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_SEG,
        ST_MRD,
        ST_MWR,
        ST_ORD,
        ST_OWR
    } mse_state_t;

    // One classified request as passed from front to back.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     keep;
    } mse_item_t;

endpackage

FILE: design/mse_front.sv
// Front end: takes input requests, marks overflow drops, registers them.
// Depends on mse_pkg.
module mse_front #(
    parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mse_pkg::DATA_W-1:0]   s_value,
    input  logic                                s_last,
    output logic                                push_valid,
    input  logic                                push_ready,
    output mse_pkg::mse_item_t                  push_item
);
    import mse_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mse_item_t        item_reg, item_next;
    logic             keep;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;
    assign keep       = cnt_reg < CNT_W'(CAPACITY);

    always_comb begin
        valid_next = valid_reg && !push_ready;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next      = 1'b1;
            item_next.value = s_value;
            item_next.last  = s_last;
            item_next.keep  = keep;
            if (s_last) begin
                cnt_next = '0;
            end else if (keep) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
        item_reg <= item_next;
    end

endmodule

FILE: design/mse_queue.sv
// Short request queue between front and back ends.
// Depends on mse_pkg.
module mse_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  mse_pkg::mse_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mse_pkg::mse_item_t pop_item
);
    import mse_pkg::*;

    localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    mse_item_t        q_mem [Q_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = fill_reg < QC_W'(Q_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_item   = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QA_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QA_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QC_W'(1);
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/mse_back.sv
// Back end: element store, ping-pong bottom-up merge passes, result register.
// Depends on mse_pkg.
module mse_back #(
    parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  mse_pkg::mse_item_t                pop_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mse_pkg::DATA_W-1:0] m_value,
    output logic                              m_last
);
    import mse_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = $clog2(CAPACITY) + 2;

    logic signed [DATA_W-1:0] mem_a [CAPACITY];
    logic signed [DATA_W-1:0] mem_b [CAPACITY];
    logic signed [DATA_W-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;

    mse_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [PW-1:0]            wid_reg, wid_next;
    logic [PW-1:0]            k_reg, k_next;
    logic [PW-1:0]            i_reg, i_next;
    logic [PW-1:0]            j_reg, j_next;
    logic [PW-1:0]            mid_reg, mid_next;
    logic [PW-1:0]            hi_reg, hi_next;
    logic                     src_reg, src_next;
    logic                     ov_reg, ov_next;
    logic signed [DATA_W-1:0] od_reg, od_next;
    logic                     ol_reg, ol_next;

    logic                     we_a, we_b;
    logic [IDX_W-1:0]         wa, ra0, ra1;
    logic signed [DATA_W-1:0] wd;
    logic [PW-1:0]            cnt_ext, sum1, sum2, k_inc;
    logic signed [DATA_W-1:0] src_i, src_j;
    logic                     take_left, out_free, pass_end;

    assign cnt_ext   = PW'(cnt_reg);
    assign sum1      = k_reg + wid_reg;
    assign sum2      = k_reg + (wid_reg << 1);
    assign k_inc     = k_reg + PW'(1);
    assign src_i     = src_reg ? rd_b0_reg : rd_a0_reg;
    assign src_j     = src_reg ? rd_b1_reg : rd_a1_reg;
    assign take_left = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (src_i <= src_j));
    assign out_free  = !ov_reg || m_ready;
    assign pass_end  = k_inc == cnt_ext;

    assign m_valid = ov_reg;
    assign m_value = od_reg;
    assign m_last  = ol_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (pop_valid && pop_item.last) begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: state_next = (wid_reg < cnt_ext) ? ST_SEG : ST_ORD;
            ST_SEG:  state_next = ST_MRD;
            ST_MRD:  state_next = ST_MWR;
            ST_MWR: begin
                if (pass_end) begin
                    state_next = ST_PASS;
                end else if (k_inc == hi_reg) begin
                    state_next = ST_SEG;
                end else begin
                    state_next = ST_MRD;
                end
            end
            ST_ORD:  state_next = ST_OWR;
            ST_OWR: begin
                if (out_free) begin
                    state_next = pass_end ? ST_LOAD : ST_ORD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cnt_next  = cnt_reg;
        wid_next  = wid_reg;
        k_next    = k_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        mid_next  = mid_reg;
        hi_next   = hi_reg;
        src_next  = src_reg;
        ov_next   = ov_reg && !m_ready;
        od_next   = od_reg;
        ol_next   = ol_reg;
        we_a      = 1'b0;
        we_b      = 1'b0;
        wa        = k_reg[IDX_W-1:0];
        wd        = take_left ? src_i : src_j;
        ra0       = i_reg[IDX_W-1:0];
        ra1       = j_reg[IDX_W-1:0];
        pop_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    if (pop_item.keep) begin
                        we_a     = 1'b1;
                        wa       = cnt_reg[IDX_W-1:0];
                        wd       = pop_item.value;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (pop_item.last) begin
                        wid_next = PW'(1);
                        src_next = 1'b0;
                        k_next   = '0;
                    end
                end
            end
            ST_PASS: k_next = '0;
            ST_SEG: begin
                i_next   = k_reg;
                mid_next = (sum1 < cnt_ext) ? sum1 : cnt_ext;
                j_next   = (sum1 < cnt_ext) ? sum1 : cnt_ext;
                hi_next  = (sum2 < cnt_ext) ? sum2 : cnt_ext;
            end
            ST_MRD: begin
            end
            ST_MWR: begin
                we_a   = src_reg;
                we_b   = !src_reg;
                k_next = k_inc;
                if (take_left) begin
                    i_next = i_reg + PW'(1);
                end else begin
                    j_next = j_reg + PW'(1);
                end
                if (pass_end) begin
                    wid_next = wid_reg << 1;
                    src_next = !src_reg;
                end
            end
            ST_ORD: ra0 = k_reg[IDX_W-1:0];
            ST_OWR: begin
                ra0 = k_reg[IDX_W-1:0];
                if (out_free) begin
                    ov_next = 1'b1;
                    od_next = src_reg ? rd_b0_reg : rd_a0_reg;
                    ol_next = pass_end;
                    if (pass_end) begin
                        cnt_next = '0;
                    end else begin
                        k_next = k_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[wa] <= wd;
        end
        if (we_b) begin
            mem_b[wa] <= wd;
        end
        rd_a0_reg <= mem_a[ra0];
        rd_a1_reg <= mem_a[ra1];
        rd_b0_reg <= mem_b[ra0];
        rd_b1_reg <= mem_b[ra1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
        wid_reg <= wid_next;
        k_reg   <= k_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        src_reg <= src_next;
        od_reg  <= od_next;
        ol_reg  <= ol_next;
    end

endmodule

FILE: design/merge_sort_engine.sv
// Top level of the merge sort engine: front end, request queue, back end.
// Depends on mse_pkg, mse_front, mse_queue, mse_back.
//
//  channel  | dir | tdata            | tlast
//  s_axis   | in  | [31:0] value     | last
//  m_axis   | out | [31:0] sorted    | final_res
//
// Loading: one request per cycle into the element store in ST_LOAD. Sort:
// ceil(log2 n) passes, each begun in ST_PASS; each run pair (a lone tail run
// counts as one) is set up in ST_SEG and each element moved by a registered
// two-port store read (ST_MRD), then compare and write (ST_MWR). Output: each
// result is read from the store (ST_ORD), then registered (ST_OWR); results
// leave a register, so a stalled m_axis blocks only the back end. Reset is
// synchronous and needs no clearing pass; the store is written before it is read.
module merge_sort_engine #(
    parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [mse_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic signed [mse_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] sorted_value
    output logic                              m_axis_tlast
);
    import mse_pkg::*;

    logic      f_valid, f_ready, b_valid, b_ready;
    mse_item_t f_item, b_item;

    mse_front #(.CAPACITY(CAPACITY)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_value    (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item)
    );

    mse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    mse_back #(.CAPACITY(CAPACITY)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_item  (b_item),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_value   (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for merge_sort_engine: drives value sets over s_axis, predicts the stable sorted
// output and checks every m_axis request against it. Bursty sender, patterned receiver stalls.
// Depends on mse_pkg and the merge_sort_engine RTL.
module tb;
    import mse_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } sort_req_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [DATA_W-1:0] s_axis_tdata = '0;
    logic                     s_axis_tlast = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0] m_axis_tdata;
    logic                     m_axis_tlast;

    sort_req_t                req_q[$];
    logic signed [DATA_W-1:0] held_set[$];
    logic signed [DATA_W-1:0] exp_sorted[$];
    logic                     exp_final[$];
    int                       err_count = 0;
    int                       burst_left = 0;
    int                       gap_left = 0;
    int                       cyc = 0;

    merge_sort_engine #(.CAPACITY(CAP)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] sorted_value
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic add_req(input logic signed [DATA_W-1:0] v, input logic l);
        sort_req_t r;
        r.value = v;
        r.last  = l;
        req_q.push_back(r);
    endtask

    // stimulus
    initial begin
        int n_items;
        int set_len;
        int kind;
        logic signed [DATA_W-1:0] v;

        // extremes and sign boundaries
        add_req(32'sh7fffffff, 1'b0);
        add_req(32'sh80000000, 1'b0);
        add_req(32'sh00000000, 1'b0);
        add_req(32'shffffffff, 1'b0);
        add_req(32'sh00000001, 1'b1);
        // single-element set
        add_req(32'sh12345678, 1'b1);
        // duplicates keep arrival order
        add_req(32'sd5, 1'b0);
        add_req(32'sd5, 1'b0);
        add_req(-32'sd5, 1'b0);
        add_req(32'sd5, 1'b1);
        // overflow: 17th value is dropped but its last mark starts the sort
        for (int i = 0; i < CAP + 1; i++)
            add_req(32'sd1000 - 32'sd37 * i, i == CAP);

        n_items = req_q.size();
        while (n_items < 180) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 1, CAP + 6)
                                                  : $urandom_range(1, 8);
            kind = $urandom_range(0, 3);
            for (int i = 0; i < set_len; i++) begin
                case (kind)
                    0: v = $urandom_range(0, 6) - 3;
                    1: v = ($urandom_range(0, 1) == 1) ? 32'sh7fffffff - $urandom_range(0, 2)
                                                       : 32'sh80000000 + $urandom_range(0, 2);
                    default: v = $urandom;
                endcase
                add_req(v, i == set_len - 1);
            end
            n_items += set_len;
        end
    end

    // sender: bursts with random gaps; predicts the sorted output on each accepted last
    always @(posedge aclk) begin : drive_proc
        int i;
        int j;
        logic signed [DATA_W-1:0] key;
        sort_req_t r;

        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_set.size() < CAP)
                    held_set.push_back(s_axis_tdata);
                if (s_axis_tlast) begin
                    // stable insertion sort
                    for (i = 1; i < held_set.size(); i++) begin
                        key = held_set[i];
                        j = i - 1;
                        while (j >= 0 && held_set[j] > key) begin
                            held_set[j + 1] = held_set[j];
                            j--;
                        end
                        held_set[j + 1] = key;
                    end
                    for (i = 0; i < held_set.size(); i++) begin
                        exp_sorted.push_back(held_set[i]);
                        exp_final.push_back(i == held_set.size() - 1);
                    end
                    held_set.delete();
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    r = req_q.pop_front();
                    s_axis_tdata  <= r.value;
                    s_axis_tlast  <= r.last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, cycling through four modes
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        case ((cyc / 97) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ((cyc % 7) < 3);
            default: m_axis_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (exp_sorted.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: unexpected result value=%0d last=%0b",
                             m_axis_tdata, m_axis_tlast);
            end else begin
                if (m_axis_tdata !== exp_sorted[0] || m_axis_tlast !== exp_final[0]) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: expected value=%0d last=%0b, got value=%0d last=%0b",
                                 exp_sorted[0], exp_final[0], m_axis_tdata, m_axis_tlast);
                end
                exp_sorted.pop_front();
                exp_final.pop_front();
            end
        end
    end

    // end of run
    initial begin
        @(posedge aresetn);
        while (req_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (exp_sorted.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
design/mse_pkg.sv
design/mse_front.sv
design/mse_queue.sv
design/mse_back.sv
design/merge_sort_engine.sv
test/tb.sv
